// ===== hdl/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg: shared types, constants and functions of the SHA-256/HMAC engine
// Round constants, initial hash values, sigma functions, queue item and
// configuration bundles.
// ----------------------------------------------------------------------------
package hse_pkg;

   localparam int MAX_KEY_BYTES = 32;
   localparam int KLEN_W        = 6;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = 2;

   localparam logic [7:0] IPAD     = 8'h36;
   localparam logic [7:0] OPAD     = 8'h5c;
   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [2:0] CSR_MODE  = 3'd0;
   localparam logic [2:0] CSR_KLEN  = 3'd1;
   localparam logic [2:0] CSR_KEY0  = 3'd2;
   localparam logic [2:0] CSR_KEY1  = 3'd3;
   localparam logic [2:0] CSR_KEY2  = 3'd4;
   localparam logic [2:0] CSR_KEY3  = 3'd5;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_HMAC  = 2'd1;
   localparam logic [1:0] PH_PLAIN = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_KEY, S_MSG, S_P80, S_PZ, S_LEN, S_FIN, S_DIG, S_ROUND, S_ADD, S_OUT
   } state_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  cnt;
      logic        last;
   } item_type;

   typedef struct packed {
      logic         mode;
      logic [5:0]   klen;
      logic [255:0] key;
   } cfg_type;

   typedef logic [31:0] word_type;

   function automatic logic [31:0] iv_word(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] r;
      case (t)
         6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
         6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
         6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
         6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
         6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
         6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
         6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
         6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
         6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
         6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
         6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
         default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// ===== hdl/hse_front.sv =====
// ----------------------------------------------------------------------------
// hse_front: input beat queue
// Accepts message beats, clamps the byte count and holds them in a short
// queue for the hashing back end.
// ----------------------------------------------------------------------------
module hse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       in_word,
   input  logic [2:0]        in_cnt,
   input  logic              in_last,
   input  logic              in_valid,
   output logic              in_ready,
   output hse_pkg::item_type item,
   output logic              item_valid,
   input  logic              item_pop
);
   import hse_pkg::*;

   item_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   num_ff, num_in;
   logic              push, pop;
   item_type          norm;

   // clamp oversized counts to a full word
   always_comb begin
      norm.word = in_word;
      norm.cnt  = (in_cnt > 3'd4) ? 3'd4 : in_cnt;
      norm.last = in_last;
   end

   assign in_ready   = (num_ff != QUEUE_DEPTH[QPTR_W:0]);
   assign item_valid = (num_ff != '0);
   assign item       = q_ff[rd_ff];
   assign push       = in_valid && in_ready;
   assign pop        = item_pop && item_valid;

   // advance pointers and fill count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      num_in = num_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         num_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         num_ff <= num_in;
      end
   end

   // store the beat
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= norm;
      end
   end

endmodule

// ===== hdl/hse_core.sv =====
// ----------------------------------------------------------------------------
// hse_core: SHA-256 / HMAC sequencer and round unit
// Packs bytes into a 16-word shift line, runs 64 rounds per block, pads,
// chains the outer hash and emits the digest as four 64-bit parts.
// ----------------------------------------------------------------------------
module hse_core (
   input  logic              clock,
   input  logic              reset,
   input  hse_pkg::cfg_type  cfg,
   input  hse_pkg::item_type item,
   input  logic              item_valid,
   output logic              item_pop,
   output logic [63:0]       out_digest,
   output logic [1:0]        out_index,
   output logic              out_last,
   output logic              out_valid,
   input  logic              out_ready
);
   import hse_pkg::*;

   state_type   state_ff, state_in, ret_ff, ret_in;
   word_type    cv_ff [8];
   word_type    cv_in [8];
   word_type    v_ff [8];
   word_type    v_in [8];
   word_type    w_ff [16];
   word_type    w_in [16];
   word_type    id_ff [8];
   word_type    id_in [8];
   logic [5:0]  cnt_ff, cnt_in, fill_ff, fill_in, rnd_ff, rnd_in;
   logic [2:0]  bi_ff, bi_in;
   logic [63:0] bits_ff, bits_in;
   logic [1:0]  phase_ff, phase_in, part_ff, part_in;
   logic        outer_ff, outer_in;
   logic [7:0]  padv_ff, padv_in;
   logic [63:0] od_ff, od_in;
   logic [1:0]  oi_ff, oi_in;
   logic        ol_ff, ol_in, ov_ff, ov_in;
   logic        put;
   logic [7:0]  pbyte;
   logic [5:0]  klen;
   logic [7:0]  kbyte;
   logic [31:0] t1, t2, wnew;

   assign out_digest = od_ff;
   assign out_index  = oi_ff;
   assign out_last   = ol_ff;
   assign out_valid  = ov_ff;

   // key byte for the pad block, zero beyond the key length
   always_comb begin
      klen  = (cfg.klen > MAX_KEY_BYTES[5:0]) ? MAX_KEY_BYTES[5:0] : cfg.klen;
      kbyte = (cnt_ff < klen) ? cfg.key[8'd255 - {cnt_ff[4:0], 3'b000} -: 8] : 8'h00;
   end

   // round arithmetic
   always_comb begin
      t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + round_k(rnd_ff) + w_ff[0];
      t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      wnew = ssig1(w_ff[14]) + w_ff[9] + ssig0(w_ff[1]) + w_ff[0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cv_in    = cv_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      id_in    = id_ff;
      cnt_in   = cnt_ff;
      fill_in  = fill_ff;
      rnd_in   = rnd_ff;
      bi_in    = bi_ff;
      bits_in  = bits_ff;
      phase_in = phase_ff;
      part_in  = part_ff;
      outer_in = outer_ff;
      padv_in  = padv_ff;
      od_in    = od_ff;
      oi_in    = oi_ff;
      ol_in    = ol_ff;
      ov_in    = (ov_ff && out_ready) ? 1'b0 : ov_ff;
      put      = 1'b0;
      pbyte    = 8'h00;
      item_pop = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               if (phase_ff == PH_IDLE) begin
                  for (int i = 0; i < 8; i++) cv_in[i] = iv_word(3'(i));
                  fill_in  = '0;
                  bits_in  = '0;
                  outer_in = 1'b0;
                  cnt_in   = '0;
                  bi_in    = '0;
                  if (cfg.mode) begin
                     phase_in = PH_HMAC;
                     padv_in  = IPAD;
                     state_in = S_KEY;
                  end else begin
                     phase_in = PH_PLAIN;
                     state_in = S_MSG;
                  end
               end else begin
                  bi_in    = '0;
                  state_in = S_MSG;
               end
            end
         end
         S_KEY: begin
            put    = 1'b1;
            pbyte  = kbyte ^ padv_ff;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               bits_in  = bits_ff + 64'd512;
               cnt_in   = '0;
               bi_in    = '0;
               state_in = outer_ff ? S_DIG : S_MSG;
            end
         end
         S_MSG: begin
            if (bi_ff < item.cnt) begin
               put     = 1'b1;
               pbyte   = item.word[5'd31 - {bi_ff[1:0], 3'b000} -: 8];
               bits_in = bits_ff + 64'd8;
               bi_in   = bi_ff + 3'd1;
            end else begin
               item_pop = 1'b1;
               bi_in    = '0;
               state_in = item.last ? S_P80 : S_IDLE;
            end
         end
         S_P80: begin
            put      = 1'b1;
            pbyte    = PAD_MARK;
            state_in = S_PZ;
         end
         S_PZ: begin
            if (fill_ff == 6'd56) begin
               cnt_in   = '0;
               state_in = S_LEN;
            end else begin
               put = 1'b1;
            end
         end
         S_LEN: begin
            put    = 1'b1;
            pbyte  = bits_ff[6'd63 - {cnt_ff[2:0], 3'b000} -: 8];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd7) begin
               cnt_in   = '0;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (phase_ff == PH_HMAC && !outer_ff) begin
               id_in = cv_ff;
               for (int i = 0; i < 8; i++) cv_in[i] = iv_word(3'(i));
               fill_in  = '0;
               bits_in  = '0;
               outer_in = 1'b1;
               padv_in  = OPAD;
               cnt_in   = '0;
               state_in = S_KEY;
            end else begin
               part_in  = '0;
               state_in = S_OUT;
            end
         end
         S_DIG: begin
            put     = 1'b1;
            pbyte   = id_ff[cnt_ff[4:2]][5'd31 - {cnt_ff[1:0], 3'b000} -: 8];
            bits_in = bits_ff + 64'd8;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               cnt_in   = '0;
               state_in = S_P80;
            end
         end
         S_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = wnew;
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = S_ADD;
         end
         S_ADD: begin
            for (int i = 0; i < 8; i++) cv_in[i] = cv_ff[i] + v_ff[i];
            state_in = ret_ff;
         end
         S_OUT: begin
            if (!ov_ff || out_ready) begin
               ov_in   = 1'b1;
               od_in   = {cv_ff[{part_ff, 1'b0}], cv_ff[{part_ff, 1'b1}]};
               oi_in   = part_ff;
               ol_in   = (part_ff == 2'd3);
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  phase_in = PH_IDLE;
                  outer_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // shift a byte into the block; start the rounds when it fills
      if (put) begin
         for (int i = 0; i < 15; i++) w_in[i] = {w_ff[i][23:0], w_ff[i+1][31:24]};
         w_in[15] = {w_ff[15][23:0], pbyte};
         fill_in  = fill_ff + 6'd1;
         if (fill_ff == 6'd63) begin
            ret_in   = state_in;
            state_in = S_ROUND;
            v_in     = cv_ff;
            rnd_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         cnt_ff   <= '0;
         fill_ff  <= '0;
         rnd_ff   <= '0;
         bi_ff    <= '0;
         bits_ff  <= '0;
         phase_ff <= PH_IDLE;
         part_ff  <= '0;
         outer_ff <= 1'b0;
         ov_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= iv_word(3'(i));
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
         fill_ff  <= fill_in;
         rnd_ff   <= rnd_in;
         bi_ff    <= bi_in;
         bits_ff  <= bits_in;
         phase_ff <= phase_in;
         part_ff  <= part_in;
         outer_ff <= outer_in;
         ov_ff    <= ov_in;
         cv_ff    <= cv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      w_ff    <= w_in;
      id_ff   <= id_in;
      padv_ff <= padv_in;
      od_ff   <= od_in;
      oi_ff   <= oi_in;
      ol_ff   <= ol_in;
   end

endmodule

// ===== hdl/hmac_sha256_engine.sv =====
// Each 64-byte block is packed one byte per cycle outside the rounds, then runs
// through the round unit and is added into the chaining value; every beat also
// takes an issue and a release step, padding blocks follow, and in HMAC mode a
// key block comes before and a key and digest pass after; four digest beats
// follow, one per cycle while rsp_tready is high. The byte-wide packer and the
// single round unit set the speed; a 4-beat queue buffers input.
// Reset: synchronous, active high; clears configuration, queue and sequencer.
// ----------------------------------------------------------------------------
// hmac_sha256_engine: streaming SHA-256 and HMAC-SHA256 engine
// Configuration registers, input queue and hashing back end.
// ----------------------------------------------------------------------------
module hmac_sha256_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_word [31:0], byte_count [34:32], zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // digest_part [63:0], part_index [65:64], zero fill
   output logic        rsp_tlast
);
   import hse_pkg::*;

   cfg_type     cfg_ff;
   item_type    item;
   logic        item_valid, item_pop;
   logic [63:0] digest;
   logic [1:0]  pidx;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE: cfg_ff.mode <= csr_wdata[0];
            CSR_KLEN: cfg_ff.klen <= csr_wdata[5:0];
            CSR_KEY0: cfg_ff.key[255:192] <= csr_wdata;
            CSR_KEY1: cfg_ff.key[191:128] <= csr_wdata;
            CSR_KEY2: cfg_ff.key[127:64]  <= csr_wdata;
            CSR_KEY3: cfg_ff.key[63:0]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   hse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_word    (req_tdata[31:0]),
      .in_cnt     (req_tdata[34:32]),
      .in_last    (req_tlast),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   hse_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .out_digest (digest),
      .out_index  (pidx),
      .out_last   (rsp_tlast),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {6'd0, pidx, digest};

endmodule

// ===== hdl/hse_checker.sv =====
// ----------------------------------------------------------------------------
// hse_checker: port-level checks of the engine
// Last flag against part index, output hold under stall, zero fill bits and reset behaviour.
// ----------------------------------------------------------------------------
module hse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);

   // hold a stalled digest beat
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled digest beat changed");

   // last flag marks the fourth part only
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[65:64] == 2'd3)))
      else $error("last flag and part index disagree");

   // no beat straight after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("digest beat valid after reset");

   // fill bits stay zero
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:66] == 6'd0)
      else $error("nonzero fill bits");

endmodule

bind hmac_sha256_engine hse_checker u_hse_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
